### hdl/hfa_pkg.sv
// shared types, constants and helpers for the hermitian fill address generator
package hfa_pkg;

	localparam int DIM_LIM    = 4;
	localparam int DIM_W      = $clog2(DIM_LIM);
	localparam int IDX_W      = 13;
	localparam int LANE_W     = 6;
	localparam int VL_W       = 7;
	localparam int ND_W       = 3;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam int LANE_LIMIT = 64;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_NUM_DIMS = 3'd0;
	localparam reg_idx_t REG_SIZE0    = 3'd1;
	localparam reg_idx_t REG_SIZE1    = 3'd2;
	localparam reg_idx_t REG_SIZE2    = 3'd3;
	localparam reg_idx_t REG_SIZE3    = 3'd4;
	localparam reg_idx_t REG_VEC_LEN  = 3'd5;

	typedef enum logic [1:0] {
		ST_PAIR      = 2'd0,
		ST_DONE      = 2'd1,
		ST_TOO_LARGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CHK_IDLE,
		CHK_LOAD,
		CHK_DIM
	} chk_state_t;

	typedef logic [DIM_LIM-1:0][IDX_W-1:0] idx_vec_t;

	typedef struct packed {
		logic [ND_W-1:0] num_dims;
		idx_vec_t        sizes;
		logic [VL_W-1:0] vec_len;
	} cfg_t;

	typedef struct packed {
		logic [LANE_W-1:0] lane;
		idx_vec_t          dst_idx;
		idx_vec_t          src_idx;
		status_t           status;
		logic              last;
	} item_t;

	// zero dimensions behaves as one
	function automatic logic [ND_W-1:0] nd_eff(input logic [ND_W-1:0] num_dims);
		return (num_dims == '0) ? ND_W'(1) : num_dims;
	endfunction

endpackage

### hdl/hfa_cfg_check.sv
// configuration size check: one dimension per cycle after each register write
module hfa_cfg_check import hfa_pkg::*; #(
	parameter int MAX_DIMS  = 4,
	parameter int ADDR_BITS = 24,
	parameter int SIZE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cfg_t cfg,
	output logic busy,
	output logic too_large
);

	localparam int PW = ADDR_BITS + 1;
	localparam int MW = PW + IDX_W;
	localparam logic [PW-1:0] LIMIT = PW'(1) << ADDR_BITS;
	localparam logic [31:0] SIZE_LIM = 32'd1 << SIZE_BITS;

	chk_state_t       state_q, state_nxt;
	logic [DIM_W-1:0] dim_q;
	logic [PW-1:0]    prod_q;
	logic             flag_q;
	logic [ND_W-1:0]  nd;
	logic [IDX_W-1:0] size_cur;
	logic [MW-1:0]    mult;
	logic             dim_used;

	assign nd       = nd_eff(cfg.num_dims);
	assign size_cur = cfg.sizes[dim_q];
	assign mult     = MW'(prod_q) * MW'(size_cur);
	assign dim_used = ND_W'(dim_q) < nd;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CHK_IDLE: if (start) state_nxt = CHK_LOAD;
			CHK_LOAD: state_nxt = start ? CHK_LOAD : CHK_DIM;
			CHK_DIM: begin
				if (start) state_nxt = CHK_LOAD;
				else if (dim_q == DIM_W'(DIM_LIM - 1)) state_nxt = CHK_IDLE;
			end
			default: state_nxt = CHK_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != CHK_IDLE);
		too_large = flag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CHK_IDLE;
			flag_q  <= 1'b0;
			dim_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				CHK_LOAD: begin
					flag_q <= (32'(nd) > MAX_DIMS) || (32'(nd) > DIM_LIM) ||
						(32'(cfg.vec_len) > LANE_LIMIT);
					dim_q  <= '0;
				end
				CHK_DIM: begin
					if (dim_used) begin
						if ((32'(size_cur) > SIZE_LIM) || (mult > MW'(LIMIT)))
							flag_q <= 1'b1;
					end
					dim_q <= dim_q + DIM_W'(1);
				end
				default: ;
			endcase
		end
	end

	// running product, only meaningful while the flag is clear
	always_ff @(posedge clk) begin
		case (state_q)
			CHK_LOAD: prod_q <= PW'(cfg.vec_len);
			CHK_DIM:  if (dim_used) prod_q <= mult[PW-1:0];
			default: ;
		endcase
	end

endmodule

### hdl/hfa_addr_pipe.sv
// row-major address stages: dimensions zero and one, then one dimension per stage, then scale by vector length
module hfa_addr_pipe import hfa_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	input  item_t                in_item,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_BITS-1:0] dst_address,
	output logic [ADDR_BITS-1:0] src_address,
	output logic                 last,
	output logic [1:0]           status
);

	localparam int HW = ADDR_BITS + IDX_W;
	localparam int FW = ADDR_BITS + VL_W;

	function automatic logic [ADDR_BITS-1:0] horner(
		input logic [ADDR_BITS-1:0] lin,
		input logic [IDX_W-1:0]     size,
		input logic [IDX_W-1:0]     idx,
		input logic                 used
	);
		logic [HW-1:0] p;
		p = HW'(lin) * HW'(size) + HW'(idx);
		return used ? p[ADDR_BITS-1:0] : lin;
	endfunction

	function automatic logic [ADDR_BITS-1:0] scale(
		input logic [ADDR_BITS-1:0] lin,
		input logic [VL_W-1:0]      vl,
		input logic [LANE_W-1:0]    lane
	);
		logic [FW-1:0] p;
		p = FW'(lin) * FW'(vl) + FW'(lane);
		return p[ADDR_BITS-1:0];
	endfunction

	logic [ND_W-1:0]      nd;
	logic                 en_s2, en_s3, en_s4, en_s5;
	logic                 v_s2, v_s3, v_s4, v_s5;
	item_t                item_s2, item_s3, item_s4;
	logic [ADDR_BITS-1:0] dlin_s2, dlin_s3, dlin_s4;
	logic [ADDR_BITS-1:0] slin_s2, slin_s3, slin_s4;
	logic [ADDR_BITS-1:0] dst_s5, src_s5;
	logic                 last_s5;
	status_t              status_s5;

	assign nd = nd_eff(cfg.num_dims);

	// a stage moves when it is empty or the one after it moves
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s2) v_s2 <= in_valid;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			item_s2 <= in_item;
			dlin_s2 <= horner(ADDR_BITS'(in_item.dst_idx[0]), cfg.sizes[1],
				in_item.dst_idx[1], nd > ND_W'(1));
			slin_s2 <= horner(ADDR_BITS'(in_item.src_idx[0]), cfg.sizes[1],
				in_item.src_idx[1], nd > ND_W'(1));
		end
		if (en_s3 && v_s2) begin
			item_s3 <= item_s2;
			dlin_s3 <= horner(dlin_s2, cfg.sizes[2], item_s2.dst_idx[2], nd > ND_W'(2));
			slin_s3 <= horner(slin_s2, cfg.sizes[2], item_s2.src_idx[2], nd > ND_W'(2));
		end
		if (en_s4 && v_s3) begin
			item_s4 <= item_s3;
			dlin_s4 <= horner(dlin_s3, cfg.sizes[3], item_s3.dst_idx[3], nd > ND_W'(3));
			slin_s4 <= horner(slin_s3, cfg.sizes[3], item_s3.src_idx[3], nd > ND_W'(3));
		end
		if (en_s5 && v_s4) begin
			status_s5 <= item_s4.status;
			// no pair: addresses and last read as zero
			if (item_s4.status == ST_PAIR) begin
				dst_s5  <= scale(dlin_s4, cfg.vec_len, item_s4.lane);
				src_s5  <= scale(slin_s4, cfg.vec_len, item_s4.lane);
				last_s5 <= item_s4.last;
			end else begin
				dst_s5  <= '0;
				src_s5  <= '0;
				last_s5 <= 1'b0;
			end
		end
	end

	assign out_valid   = v_s5;
	assign dst_address = dst_s5;
	assign src_address = src_s5;
	assign last        = last_s5;
	assign status      = status_s5;

endmodule

### hdl/hermitian_fill_address_gen.sv
// hermitian fill address generator: walk state, register port and address pipeline
// an accepted item is registered in s1 to s5 on its way to the pair channel
// throughput: one item per cycle unless stalled; walk state updates in accept cycle
// after every register write the size check runs; no item is taken while it is busy
// reset: asynchronous, registers return to 1, no walk active, pipeline empty
module hermitian_fill_address_gen import hfa_pkg::*; #(
	parameter int MAX_DIMS  = 4,
	parameter int ADDR_BITS = 24,
	parameter int SIZE_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic                 restart,
	output logic                 pair_valid,
	input  logic                 pair_ready,
	output logic [ADDR_BITS-1:0] dst_address,
	output logic [ADDR_BITS-1:0] src_address,
	output logic                 last,
	output logic [1:0]           status
);

	cfg_t              cfg_q;
	logic              cfg_we;
	reg_idx_t          reg_idx;
	logic              chk_busy, too_large;

	idx_vec_t          pos_q;
	logic [LANE_W-1:0] lane_q;
	logic              done_q;

	logic              cmd_fire, en_s1, pipe_ready;
	logic              v_s1;
	item_t             item_s1;

	logic [ND_W-1:0]   nd;
	logic [DIM_W-1:0]  last_d;
	logic [IDX_W-1:0]  half;
	idx_vec_t          eff_idx, src_idx, next_idx;
	logic [LANE_W-1:0] eff_lane, next_lane;
	logic              eff_done, pair_ok, walk_end, lane_wrap, idx_ok, carry;
	logic [VL_W-1:0]   lane_inc;
	logic [IDX_W:0]    inc;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_dims <= ND_W'(1);
			cfg_q.sizes    <= {DIM_LIM{IDX_W'(1)}};
			cfg_q.vec_len  <= VL_W'(1);
		end else if (cfg_we) begin
			case (reg_idx)
				REG_NUM_DIMS: cfg_q.num_dims <= pwdata[ND_W-1:0];
				REG_SIZE0:    cfg_q.sizes[0] <= pwdata[IDX_W-1:0];
				REG_SIZE1:    cfg_q.sizes[1] <= pwdata[IDX_W-1:0];
				REG_SIZE2:    cfg_q.sizes[2] <= pwdata[IDX_W-1:0];
				REG_SIZE3:    cfg_q.sizes[3] <= pwdata[IDX_W-1:0];
				REG_VEC_LEN:  cfg_q.vec_len  <= pwdata[VL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_DIMS: prdata = PDATA_W'(cfg_q.num_dims);
			REG_SIZE0:    prdata = PDATA_W'(cfg_q.sizes[0]);
			REG_SIZE1:    prdata = PDATA_W'(cfg_q.sizes[1]);
			REG_SIZE2:    prdata = PDATA_W'(cfg_q.sizes[2]);
			REG_SIZE3:    prdata = PDATA_W'(cfg_q.sizes[3]);
			REG_VEC_LEN:  prdata = PDATA_W'(cfg_q.vec_len);
			default:      prdata = '0;
		endcase
	end

	hfa_cfg_check #(
		.MAX_DIMS (MAX_DIMS),
		.ADDR_BITS(ADDR_BITS),
		.SIZE_BITS(SIZE_BITS)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_we),
		.cfg      (cfg_q),
		.busy     (chk_busy),
		.too_large(too_large)
	);

	// walk state: position for this item and the next one
	assign nd     = nd_eff(cfg_q.num_dims);
	assign last_d = DIM_W'(nd - ND_W'(1));
	assign half   = (cfg_q.sizes[last_d] >> 1) + IDX_W'(1);

	always_comb begin
		eff_lane = restart ? '0 : lane_q;
		eff_done = restart ? 1'b0 : done_q;
		idx_ok   = 1'b1;
		for (int d = 0; d < DIM_LIM; d++) begin
			if (restart) eff_idx[d] = (DIM_W'(d) == last_d) ? half : '0;
			else         eff_idx[d] = pos_q[d];
			src_idx[d] = (eff_idx[d] == '0) ? '0 : cfg_q.sizes[d] - eff_idx[d];
			if ((ND_W'(d) < nd) && (eff_idx[d] >= cfg_q.sizes[d])) idx_ok = 1'b0;
		end
		pair_ok = !eff_done && idx_ok && ({1'b0, eff_lane} < cfg_q.vec_len) &&
			(eff_idx[last_d] >= half);

		lane_inc  = {1'b0, eff_lane} + VL_W'(1);
		lane_wrap = lane_inc >= cfg_q.vec_len;
		next_lane = lane_wrap ? '0 : lane_inc[LANE_W-1:0];

		// carry from the fastest dimension towards dimension zero
		carry    = lane_wrap;
		next_idx = eff_idx;
		inc      = '0;
		for (int d = DIM_LIM - 1; d >= 0; d--) begin
			if (ND_W'(d) < nd) begin
				inc = {1'b0, eff_idx[d]} + (IDX_W+1)'(1);
				if (carry) begin
					if (inc >= {1'b0, cfg_q.sizes[d]}) begin
						next_idx[d] = (DIM_W'(d) == last_d) ? half : '0;
					end else begin
						next_idx[d] = inc[IDX_W-1:0];
						carry       = 1'b0;
					end
				end
			end
		end
		walk_end = carry;
	end

	assign en_s1     = !v_s1 || pipe_ready;
	assign cmd_ready = en_s1 && !chk_busy;
	assign cmd_fire  = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lane_q <= '0;
			done_q <= 1'b1;
			v_s1   <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= cmd_fire;
			if (cmd_fire) begin
				if (too_large) begin
					done_q <= 1'b1;
				end else begin
					pos_q  <= pair_ok ? next_idx : eff_idx;
					lane_q <= pair_ok ? next_lane : eff_lane;
					done_q <= pair_ok ? walk_end : 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_s1.lane    <= eff_lane;
			item_s1.dst_idx <= eff_idx;
			item_s1.src_idx <= src_idx;
			item_s1.last    <= !too_large && pair_ok && walk_end;
			if (too_large)    item_s1.status <= ST_TOO_LARGE;
			else if (pair_ok) item_s1.status <= ST_PAIR;
			else              item_s1.status <= ST_DONE;
		end
	end

	hfa_addr_pipe #(
		.ADDR_BITS(ADDR_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (v_s1),
		.in_item    (item_s1),
		.in_ready   (pipe_ready),
		.out_valid  (pair_valid),
		.out_ready  (pair_ready),
		.dst_address(dst_address),
		.src_address(src_address),
		.last       (last),
		.status     (status)
	);

`ifndef SYNTHESIS
	// no item may slip in before the size check has seen a new register value
	a_check_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !cmd_ready)
		else $error("item accepted right after a register write");

	// a walk only starts on a restart item
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(done_q) |-> $past(cmd_fire && restart))
		else $error("walk became active without restart");

	// results that carry no pair have zero addresses and no last flag
	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && (status != ST_PAIR) |->
			(dst_address == '0) && (src_address == '0) && !last)
		else $error("non-pair result with address or last set");

	// a too-large configuration never produces a pair
	a_too_large: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && too_large |=> (item_s1.status == ST_TOO_LARGE) && done_q)
		else $error("oversized configuration did not end the walk");
`endif

endmodule

### tb/tb_top.sv
// self-checking testbench for the hermitian fill address generator
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hfa_pkg::*;

	localparam int MAX_DIMS     = 4;
	localparam int ADDR_BITS    = 24;
	localparam int SIZE_BITS    = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TOTAL_ITEMS  = 1350;
	localparam int HOLD_CYCLES  = 300;
	localparam int SQUEEZE_ITEMS = 120;
	localparam int DIR_ROWS     = 26;

	typedef struct packed {
		logic [ADDR_BITS-1:0] dst;
		logic [ADDR_BITS-1:0] src;
		logic                 last;
		status_t              st;
	} pair_t;

	typedef struct packed {
		bit               cfg;
		logic [ND_W-1:0]  nd;
		logic [IDX_W-1:0] s0;
		logic [IDX_W-1:0] s1;
		logic [IDX_W-1:0] s2;
		logic [IDX_W-1:0] s3;
		logic [VL_W-1:0]  vl;
		bit               rs;
		bit               fixed;
		pair_t            want;
	} row_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_THREE_OF_FOUR,
		RX_SPARSE
	} rx_mode_t;

	localparam pair_t NO_PAIR = '{'0, '0, 1'b0, ST_DONE};
	localparam pair_t TOO_BIG = '{'0, '0, 1'b0, ST_TOO_LARGE};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	logic                 restart = 1'b0;
	logic                 pair_valid;
	logic                 pair_ready = 1'b0;
	logic [ADDR_BITS-1:0] dst_address;
	logic [ADDR_BITS-1:0] src_address;
	logic                 last;
	logic [1:0]           status;

	hermitian_fill_address_gen #(
		.MAX_DIMS (MAX_DIMS),
		.ADDR_BITS(ADDR_BITS),
		.SIZE_BITS(SIZE_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.restart    (restart),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.dst_address(dst_address),
		.src_address(src_address),
		.last       (last),
		.status     (status)
	);

	// mirrored registers and walk state
	logic [ND_W-1:0]   cfg_dims = ND_W'(1);
	logic [IDX_W-1:0]  cfg_len [DIM_LIM] = '{default: IDX_W'(1)};
	logic [VL_W-1:0]   cfg_vlen = VL_W'(1);
	logic [IDX_W-1:0]  walk_pos [DIM_LIM] = '{default: '0};
	logic [VL_W-1:0]   walk_lane = '0;
	bit                walk_active = 1'b0;

	pair_t pending_pairs [$];
	int    mismatches = 0;
	int    items_sent = 0;
	int    burst_left = 0;
	int    cycle_count = 0;
	bit    steady = 1'b0;
	bit    hold_req = 1'b0;
	pair_t seen;
	pair_t due;

	row_t dir_tab [DIR_ROWS] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 1, NO_PAIR},      // no walk after reset
		'{0, 0, 0, 0, 0, 0, 0, 1, 1, NO_PAIR},      // single point, nothing to fill
		'{1, 1, 4, 1, 1, 1, 1, 1, 1, '{24'd3, 24'd1, 1'b1, ST_PAIR}},
		'{0, 0, 0, 0, 0, 0, 0, 0, 1, NO_PAIR},      // walk already finished
		'{1, 1, 8, 1, 1, 1, 2, 1, 0, NO_PAIR},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, NO_PAIR},
		'{0, 0, 0, 0, 0, 0, 0, 1, 0, NO_PAIR},      // restart mid-walk
		'{1, 3, 3, 4, 5, 1, 3, 1, 0, NO_PAIR},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, NO_PAIR},
		'{1, 0, 5, 1, 1, 1, 1, 1, 1, '{24'd3, 24'd2, 1'b0, ST_PAIR}},
		'{1, 5, 1, 1, 1, 1, 1, 1, 1, TOO_BIG},
		'{1, 7, 1, 1, 1, 1, 1, 0, 1, TOO_BIG},
		'{1, 4, 4096, 4096, 4096, 4096, 64, 1, 1, TOO_BIG},
		'{1, 1, 4097, 1, 1, 1, 1, 1, 1, TOO_BIG},
		'{1, 1, 8191, 1, 1, 1, 127, 1, 1, TOO_BIG},
		'{1, 1, 4, 1, 1, 1, 65, 1, 1, TOO_BIG},
		'{1, 1, 4096, 1, 1, 1, 64, 1, 1, '{24'd131136, 24'd131008, 1'b0, ST_PAIR}},
		'{1, 2, 4096, 4096, 1, 1, 1, 1, 1, '{24'd2049, 24'd2047, 1'b0, ST_PAIR}},
		'{1, 4, 4096, 4096, 1, 1, 2, 1, 1, TOO_BIG},
		'{1, 2, 4, 6, 1, 1, 0, 1, 1, NO_PAIR},      // zero lanes
		'{1, 2, 0, 6, 1, 1, 1, 1, 1, NO_PAIR},      // zero-length slow dimension
		'{1, 1, 2, 1, 1, 1, 1, 1, 1, NO_PAIR},
		'{1, 1, 8, 1, 1, 1, 1, 1, 1, '{24'd5, 24'd3, 1'b0, ST_PAIR}},
		'{1, 1, 4, 1, 1, 1, 1, 0, 1, NO_PAIR},      // shrunk under an active walk
		'{1, 4, 2, 3, 4, 8, 1, 1, 0, NO_PAIR},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, NO_PAIR}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// next copy pair for one accepted item; updates the walk state
	function automatic pair_t next_copy_pair(input logic rs);
		pair_t           r;
		int unsigned     nd, n, d, sz, ix;
		longint unsigned dlin, slin, prod;
		bit              too_big, ok, stepping;
		r = NO_PAIR;
		nd = (cfg_dims == '0) ? 1 : cfg_dims;
		too_big = (nd > MAX_DIMS) || (nd > DIM_LIM) || (cfg_vlen > LANE_LIMIT);
		prod = cfg_vlen;
		for (d = 0; d < nd && !too_big; d++) begin
			if (cfg_len[d] > (1 << SIZE_BITS))
				too_big = 1'b1;
			prod = prod * cfg_len[d];
			if (prod > (64'd1 << ADDR_BITS))
				too_big = 1'b1;
		end
		if (too_big) begin
			walk_active = 1'b0;
			return TOO_BIG;
		end
		n = cfg_len[nd-1];
		if (rs) begin
			for (d = 0; d < DIM_LIM; d++)
				walk_pos[d] = '0;
			walk_pos[nd-1] = IDX_W'(n / 2 + 1);
			walk_lane = '0;
			walk_active = 1'b1;
		end
		ok = walk_active && (walk_lane < cfg_vlen) && (walk_pos[nd-1] >= n / 2 + 1);
		for (d = 0; d < nd; d++)
			if (walk_pos[d] >= cfg_len[d])
				ok = 1'b0;
		if (!ok) begin
			walk_active = 1'b0;
			return NO_PAIR;
		end
		dlin = 0;
		slin = 0;
		for (d = 0; d < nd; d++) begin
			sz = cfg_len[d];
			ix = walk_pos[d];
			dlin = dlin * sz + ix;
			slin = slin * sz + ((ix == 0) ? 0 : sz - ix);
		end
		r.dst = ADDR_BITS'(dlin * cfg_vlen + walk_lane);
		r.src = ADDR_BITS'(slin * cfg_vlen + walk_lane);
		r.st = ST_PAIR;
		// lanes first, then the fastest index, carrying towards dimension zero
		walk_lane = walk_lane + 1'b1;
		if (walk_lane >= cfg_vlen) begin
			walk_lane = '0;
			d = nd - 1;
			stepping = 1'b1;
			while (stepping) begin
				walk_pos[d] = walk_pos[d] + 1'b1;
				if (walk_pos[d] < cfg_len[d]) begin
					stepping = 1'b0;
				end else begin
					walk_pos[d] = (d == nd - 1) ? IDX_W'(n / 2 + 1) : '0;
					if (d == 0) begin
						walk_active = 1'b0;
						stepping = 1'b0;
					end else begin
						d--;
					end
				end
			end
		end
		r.last = !walk_active;
		return r;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_NUM_DIMS: cfg_dims = val[ND_W-1:0];
			REG_VEC_LEN:  cfg_vlen = val[VL_W-1:0];
			default:      cfg_len[idx - REG_SIZE0] = val[IDX_W-1:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [ND_W-1:0] nd, input logic [IDX_W-1:0] s0,
			input logic [IDX_W-1:0] s1, input logic [IDX_W-1:0] s2,
			input logic [IDX_W-1:0] s3, input logic [VL_W-1:0] vl);
		write_reg(REG_NUM_DIMS, PDATA_W'(nd));
		write_reg(REG_SIZE0, PDATA_W'(s0));
		write_reg(REG_SIZE1, PDATA_W'(s1));
		write_reg(REG_SIZE2, PDATA_W'(s2));
		write_reg(REG_SIZE3, PDATA_W'(s3));
		write_reg(REG_VEC_LEN, PDATA_W'(vl));
	endtask

	// sender waits here until every predicted pair has come back
	task automatic drain_pairs();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(negedge clk);
	endtask

	// offers one item in bursts with random gaps, returns the predicted pair at acceptance
	task automatic send_item(input logic rs, output pair_t pair);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
		end
		repeat (gap) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (!cmd_ready);
		burst_left--;
		items_sent++;
		pair = next_copy_pair(rs);
	endtask

	task automatic random_phase();
		logic [PDATA_W-1:0] word;
		int unsigned        k, nd_u, n, len, count;
		bit                 fresh;
		pair_t              pair;
		drain_pairs();
		if ($urandom_range(0, 3) != 0) begin
			word = $urandom;
			if ($urandom_range(0, 9) == 0)
				word[ND_W-1:0] = ND_W'($urandom_range(0, 7));
			else
				word[ND_W-1:0] = ND_W'($urandom_range(1, 4));
			write_reg(REG_NUM_DIMS, word);
		end
		for (k = 0; k < DIM_LIM; k++) begin
			if ($urandom_range(0, 3) != 0) begin
				word = $urandom;
				case ($urandom_range(0, 24))
					0: word[IDX_W-1:0] = IDX_W'($urandom_range(0, 2));
					1: word[IDX_W-1:0] = IDX_W'(4096);
					2: word[IDX_W-1:0] = IDX_W'($urandom_range(4097, 8191));
					3: word[IDX_W-1:0] = IDX_W'($urandom_range(1, 4096));
					default: word[IDX_W-1:0] = IDX_W'($urandom_range(1, 7));
				endcase
				write_reg(reg_idx_t'(REG_SIZE0 + k), word);
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			word = $urandom;
			case ($urandom_range(0, 11))
				0: word[VL_W-1:0] = '0;
				1: word[VL_W-1:0] = VL_W'(64);
				2: word[VL_W-1:0] = VL_W'($urandom_range(65, 127));
				3: word[VL_W-1:0] = VL_W'($urandom_range(1, 64));
				default: word[VL_W-1:0] = VL_W'($urandom_range(1, 4));
			endcase
			write_reg(REG_VEC_LEN, word);
		end
		// rough walk length so that most phases run off the end of their walk
		nd_u = (cfg_dims == '0) ? 1 : cfg_dims;
		len = 0;
		if (nd_u <= DIM_LIM) begin
			n = cfg_len[nd_u-1];
			len = ((n > 2) ? n - n / 2 - 1 : 0) * cfg_vlen;
			for (k = 0; k + 1 < nd_u; k++)
				if (len < 1000)
					len = len * cfg_len[k];
		end
		count = (len <= 70) ? len + $urandom_range(1, 3) : $urandom_range(20, 70);
		fresh = ($urandom_range(0, 5) != 0);
		for (k = 0; k < count; k++) begin
			send_item((k == 0) ? fresh : ($urandom_range(0, 39) == 0), pair);
			pending_pairs.push_back(pair);
		end
	endtask

	// receiver: changing ready pattern, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       span, tick, hold_left;
		mode = RX_OPEN;
		span = 0;
		tick = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pair_ready <= 1'b0;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					span = $urandom_range(8, 80);
				end
				span--;
				tick++;
				case (mode)
					RX_OPEN:          pair_ready <= 1'b1;
					RX_COIN:          pair_ready <= 1'($urandom_range(0, 1));
					RX_THREE_OF_FOUR: pair_ready <= (tick % 4) != 3;
					default:          pair_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pair_valid && pair_ready) begin
			seen = '{dst_address, src_address, last, status_t'(status)};
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pair: dst %0d src %0d last %0b status %0d",
						seen.dst, seen.src, seen.last, seen.st);
			end else begin
				due = pending_pairs.pop_front();
				if (seen.dst !== due.dst || seen.src !== due.src || seen.last !== due.last ||
						seen.st !== due.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pair mismatch: exp dst %0d src %0d last %0b status %0d, %s",
							due.dst, due.src, due.last, due.st,
							$sformatf("got dst %0d src %0d last %0b status %0d",
								seen.dst, seen.src, seen.last, seen.st));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("simulation failed");
		$finish;
	end

	initial begin
		pair_t pair;
		int    i, k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].cfg) begin
				drain_pairs();
				write_all(dir_tab[i].nd, dir_tab[i].s0, dir_tab[i].s1, dir_tab[i].s2,
					dir_tab[i].s3, dir_tab[i].vl);
			end
			send_item(dir_tab[i].rs, pair);
			pending_pairs.push_back(dir_tab[i].fixed ? dir_tab[i].want : pair);
		end

		// receiver holds off while items keep coming, so the input backs up
		drain_pairs();
		write_all(ND_W'(2), IDX_W'(16), IDX_W'(16), IDX_W'(1), IDX_W'(1), VL_W'(4));
		steady = 1'b1;
		hold_req = 1'b1;
		for (k = 0; k < SQUEEZE_ITEMS; k++) begin
			send_item(k == 0, pair);
			pending_pairs.push_back(pair);
		end
		steady = 1'b0;

		while (items_sent < TOTAL_ITEMS)
			random_phase();

		drain_pairs();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hdl/hfa_pkg.sv
hdl/hfa_cfg_check.sv
hdl/hfa_addr_pipe.sv
hdl/hermitian_fill_address_gen.sv
tb/tb_top.sv
